// File: sv/rcf_pkg.sv
// ---------------------------------------------------------------------------
// rcf_pkg
// Shared types, constants and register codes of the RGB 3x3 convolution filter.
// ---------------------------------------------------------------------------
package rcf_pkg;

  // default parameter values
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COEF_BITS_DEF = 8;

  // fixed field widths
  localparam int PIX_W   = 8;
  localparam int RGB_W   = 3 * PIX_W;
  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 16;
  localparam int ROW_W   = IMG_H_W + 1;   // row position may run past the height
  localparam int CH_EN_W = 3;
  localparam int IDX_W   = 3;

  // lane pipeline: products, sum, magnitude, then one quotient bit per stage
  localparam int DIV_STEPS   = PIX_W;
  localparam int LANE_STAGES = 3 + DIV_STEPS;

  // register reset values
  localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(640);
  localparam logic [IMG_H_W-1:0] IMG_H_RST = IMG_H_W'(480);
  localparam logic [CH_EN_W-1:0] CH_EN_RST = CH_EN_W'(7);

  typedef logic [RGB_W-1:0] rgb_t;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4,
    REG_CHANNEL_EN    = 3'd5,
    REG_DIVIDE_EN     = 3'd6
  } reg_idx_t;

endpackage

// File: sv/rcf_pix_in_if.sv
// ---------------------------------------------------------------------------
// rcf_pix_in_if
// Input pixel channel: command plus one RGB pixel per transfer.
// ---------------------------------------------------------------------------
interface rcf_pix_in_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [rcf_pkg::PIX_W-1:0] red_in;
  logic [rcf_pkg::PIX_W-1:0] green_in;
  logic [rcf_pkg::PIX_W-1:0] blue_in;

  modport source (output valid, command, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

// File: sv/rcf_pix_out_if.sv
// ---------------------------------------------------------------------------
// rcf_pix_out_if
// Result pixel channel: one filtered RGB pixel and frame marker per transfer.
// ---------------------------------------------------------------------------
interface rcf_pix_out_if;
  logic                     valid;
  logic                     ready;
  logic [rcf_pkg::PIX_W-1:0] red_out;
  logic [rcf_pkg::PIX_W-1:0] green_out;
  logic [rcf_pkg::PIX_W-1:0] blue_out;
  logic                     frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// File: sv/rcf_cfg_if.sv
// ---------------------------------------------------------------------------
// rcf_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface rcf_cfg_if #(
  parameter int DATA_W = 24
);
  logic                     valid;
  logic                     ready;
  logic [rcf_pkg::IDX_W-1:0] index;
  logic [DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/rcf_ram.sv
// ---------------------------------------------------------------------------
// rcf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rcf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/rcf_lane.sv
// ---------------------------------------------------------------------------
// rcf_lane
// One color lane: 3x3 multiply, sum, magnitude and bit-per-stage division
// with saturation to 8 bits.
// ---------------------------------------------------------------------------
module rcf_lane #(
  parameter int COEF_BITS = rcf_pkg::COEF_BITS_DEF
) (
  input  logic                                  clk,
  input  logic [rcf_pkg::LANE_STAGES-1:0]       en,
  input  logic [8:0][rcf_pkg::PIX_W-1:0]        pix,
  input  logic [8:0][COEF_BITS-1:0]             coef,
  input  logic [COEF_BITS+2:0]                  divisor,
  output logic [rcf_pkg::PIX_W-1:0]             res
);

  localparam int PW    = rcf_pkg::PIX_W;
  localparam int P_W   = PW + COEF_BITS + 1;
  localparam int ACC_W = P_W + 4;
  localparam int D_W   = COEF_BITS + 3;
  localparam int C_W   = ((ACC_W > D_W + PW) ? ACC_W : D_W + PW) + 1;
  localparam int NDIV  = rcf_pkg::DIV_STEPS;

  logic signed [P_W-1:0]   prod_r [9];
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] sum_c;
  logic [ACC_W-1:0]        mag_c;
  logic [ACC_W-1:0]        rem_r [NDIV+1];
  logic [PW-1:0]           q_r   [NDIV+1];
  logic                    sat_r [NDIV+1];

  // stage 0: nine signed products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 9; k++) begin
        prod_r[k] <= $signed({1'b0, pix[k]}) * $signed(coef[k]);
      end
    end
  end

  // stage 1: sum of products
  always_comb begin
    sum_c = '0;
    for (int k = 0; k < 9; k++) begin
      sum_c = sum_c + ACC_W'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      acc_r <= sum_c;
    end
  end

  // stage 2: magnitude and quotient overflow check
  assign mag_c = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rem_r[0] <= mag_c;
      q_r[0]   <= '0;
      sat_r[0] <= C_W'(mag_c) >= (C_W'(divisor) << PW);
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    localparam int BIT = NDIV - 1 - j;
    logic [C_W-1:0] trial;
    logic           ge;

    assign trial = C_W'(divisor) << BIT;
    assign ge    = C_W'(rem_r[j]) >= trial;

    always_ff @(posedge clk) begin
      if (en[3+j]) begin
        rem_r[j+1]      <= ge ? ACC_W'(C_W'(rem_r[j]) - trial) : rem_r[j];
        q_r[j+1]        <= q_r[j] | (PW'(ge) << BIT);
        sat_r[j+1]      <= sat_r[j];
      end
    end
  end

  assign res = sat_r[NDIV] ? '1 : q_r[NDIV];

endmodule

// File: sv/rgb_conv3x3_filter.sv
// ---------------------------------------------------------------------------
// rgb_conv3x3_filter
// Streaming 3x3 convolution over an RGB raster with two line stores, a 3x3
// window and three color lanes merged into one output register.
// ---------------------------------------------------------------------------
// Result path: a result is completed by the item one row plus one pixel after
//   its own input and passes stage A, stage B, the lanes and the output register.
// Throughput: one item per clock unless out_ch.ready stalls; the line store
//   memory has one read and one write per item, each lane stage one per clock.
// Reset: synchronous active-low rst_n clears counters, valid flags and the
//   registers to their defaults; line store contents stay undefined.
module rgb_conv3x3_filter #(
  parameter int MAX_WIDTH = rcf_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = rcf_pkg::COEF_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  rcf_pix_in_if.sink     in_ch,
  rcf_pix_out_if.source  out_ch,
  rcf_cfg_if.sink        cfg_ch
);

  localparam int PW     = rcf_pkg::PIX_W;
  localparam int RGB_W  = rcf_pkg::RGB_W;
  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int XC_W   = $clog2(MAX_WIDTH + 1);
  localparam int WID_W  = (XC_W > rcf_pkg::IMG_W_W) ? XC_W : rcf_pkg::IMG_W_W;
  localparam int ROW_W  = rcf_pkg::ROW_W;
  localparam int ROWB   = 3 * COEF_BITS;
  localparam int D_W    = COEF_BITS + 3;
  localparam int KS_W   = COEF_BITS + 4;
  localparam int LS     = rcf_pkg::LANE_STAGES;

  // configuration registers
  logic [rcf_pkg::IMG_W_W-1:0] img_w_r;
  logic [rcf_pkg::IMG_H_W-1:0] img_h_r;
  logic [ROWB-1:0]             krow_r [3];
  logic [rcf_pkg::CH_EN_W-1:0] chen_r;
  logic                        div_en_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= rcf_pkg::IMG_W_RST;
      img_h_r   <= rcf_pkg::IMG_H_RST;
      krow_r[0] <= '0;
      krow_r[1] <= ROWB'(1) << COEF_BITS;
      krow_r[2] <= '0;
      chen_r    <= rcf_pkg::CH_EN_RST;
      div_en_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (rcf_pkg::reg_idx_t'(cfg_ch.index))
        rcf_pkg::REG_IMAGE_WIDTH:   img_w_r   <= cfg_ch.data[rcf_pkg::IMG_W_W-1:0];
        rcf_pkg::REG_IMAGE_HEIGHT:  img_h_r   <= cfg_ch.data[rcf_pkg::IMG_H_W-1:0];
        rcf_pkg::REG_KERNEL_TOP:    krow_r[0] <= cfg_ch.data[ROWB-1:0];
        rcf_pkg::REG_KERNEL_MIDDLE: krow_r[1] <= cfg_ch.data[ROWB-1:0];
        rcf_pkg::REG_KERNEL_BOTTOM: krow_r[2] <= cfg_ch.data[ROWB-1:0];
        rcf_pkg::REG_CHANNEL_EN:    chen_r    <= cfg_ch.data[rcf_pkg::CH_EN_W-1:0];
        rcf_pkg::REG_DIVIDE_EN:     div_en_r  <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // kernel coefficients, kernel sum and lane divisor
  logic [8:0][COEF_BITS-1:0] coef;
  logic signed [KS_W-1:0]    ksum;
  logic [D_W-1:0]            divisor;

  always_comb begin
    ksum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r*3+c] = krow_r[r][c*COEF_BITS +: COEF_BITS];
        ksum = ksum + KS_W'($signed(krow_r[r][c*COEF_BITS +: COEF_BITS]));
      end
    end
  end

  assign divisor = (div_en_r && !ksum[KS_W-1] && (ksum != '0)) ? D_W'(ksum) : D_W'(1);

  // effective frame size
  logic [WID_W-1:0]            w_ext;
  logic [WID_W-1:0]            w_eff;
  logic [rcf_pkg::IMG_H_W-1:0] h_eff;
  logic [ROW_W-1:0]            h_ext;

  assign w_ext = WID_W'(img_w_r);
  assign w_eff = (w_ext < WID_W'(3)) ? WID_W'(3) :
                 (w_ext > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : w_ext;
  assign h_eff = (img_h_r < rcf_pkg::IMG_H_W'(3)) ? rcf_pkg::IMG_H_W'(3) : img_h_r;
  assign h_ext = ROW_W'(h_eff);

  // pipeline enables, output side first
  logic          v_a, v_b, out_v_r;
  logic [LS-1:0] v_l;
  logic [LS:0]   en_l;
  logic          en_a, en_b, in_fire, fire_a;

  assign en_l[LS] = !out_v_r || out_ch.ready;
  for (genvar k = 0; k < LS; k++) begin : g_en
    assign en_l[k] = !v_l[k] || en_l[k+1];
  end
  assign en_b    = !v_b || en_l[0];
  assign en_a    = !v_a || en_b;
  assign fire_a  = v_a && en_b;

  assign in_ch.ready = en_a;
  assign in_fire     = in_ch.valid && en_a;

  // position of the arriving item
  logic [X_W-1:0]   col_r, x0, col_nxt;
  logic [ROW_W-1:0] row_r, y0, row_nxt;
  logic             wrap, tail, ignore, flush, emit0, last0, filt0;
  logic [WID_W-1:0] x_inc;
  rcf_pkg::rgb_t    pix0;

  always_comb begin
    wrap  = WID_W'(col_r) >= w_eff;
    x0    = wrap ? '0 : col_r;
    y0    = wrap ? row_r + ROW_W'(1) : row_r;
    tail  = y0 >= h_ext;
    ignore = in_ch.command && !tail;
    flush = in_ch.command || tail;
    emit0 = (x0 == '0) ? (y0 >= ROW_W'(2)) : (y0 >= ROW_W'(1));
    last0 = (x0 == '0) && emit0 && (y0 >= h_ext + ROW_W'(1));
    filt0 = (x0 >= X_W'(2)) && (WID_W'(x0) <= w_eff - WID_W'(1)) &&
            (y0 >= ROW_W'(2)) && (y0 <= h_ext - ROW_W'(1));
    pix0  = flush ? '0 : {in_ch.blue_in, in_ch.green_in, in_ch.red_in};
    x_inc = WID_W'(x0) + WID_W'(1);
    if (last0) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (x_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = y0 + ROW_W'(1);
    end else begin
      col_nxt = X_W'(x_inc);
      row_nxt = y0;
    end
  end

  // a dropped flush leaves the position unchanged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire && !ignore) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage A: line store read in flight
  logic [X_W-1:0] addr_a;
  rcf_pkg::rgb_t  pix_a;
  logic           emit_a, last_a, filt_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a <= 1'b0;
    end else if (en_a) begin
      v_a <= in_fire && !ignore;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_a <= x0;
      pix_a  <= pix0;
      emit_a <= emit0;
      last_a <= last0;
      filt_a <= filt0;
    end
  end

  // line stores: upper row in the high half, lower row in the low half
  logic [2*RGB_W-1:0] ls_rdata;

  rcf_ram #(
    .WIDTH (2 * RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (fire_a),
    .waddr (addr_a),
    .wdata ({ls_rdata[RGB_W-1:0], pix_a}),
    .re    (in_fire),
    .raddr (x0),
    .rdata (ls_rdata)
  );

  // stage B: 3x3 window shifts in one column per stored item
  logic [2:0][2:0][RGB_W-1:0] win_r;
  rcf_pkg::rgb_t              pass_b;
  logic                       filt_b, last_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b <= 1'b0;
    end else if (en_b) begin
      v_b <= fire_a && emit_a;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_a) begin
      pass_b <= win_r[1][2];
      filt_b <= filt_a;
      last_b <= last_a;
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= ls_rdata[2*RGB_W-1:RGB_W];
      win_r[1][2] <= ls_rdata[RGB_W-1:0];
      win_r[2][2] <= pix_a;
    end
  end

  // color lanes
  logic [2:0][PW-1:0] lane_res;

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    logic [8:0][PW-1:0] lane_pix;

    always_comb begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          lane_pix[r*3+c] = win_r[r][c][ch*PW +: PW];
        end
      end
    end

    rcf_lane #(
      .COEF_BITS (COEF_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (en_l[LS-1:0]),
      .pix     (lane_pix),
      .coef    (coef),
      .divisor (divisor),
      .res     (lane_res[ch])
    );
  end

  // side data travelling alongside the lanes
  rcf_pkg::rgb_t pass_l [LS];
  logic          filt_l [LS];
  logic          last_l [LS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_l <= '0;
    end else begin
      if (en_l[0]) begin
        v_l[0] <= v_b;
      end
      for (int k = 1; k < LS; k++) begin
        if (en_l[k]) begin
          v_l[k] <= v_l[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_l[0]) begin
      pass_l[0] <= pass_b;
      filt_l[0] <= filt_b;
      last_l[0] <= last_b;
    end
    for (int k = 1; k < LS; k++) begin
      if (en_l[k]) begin
        pass_l[k] <= pass_l[k-1];
        filt_l[k] <= filt_l[k-1];
        last_l[k] <= last_l[k-1];
      end
    end
  end

  // merge: filtered lanes or passed-through pixel into the output register
  rcf_pkg::rgb_t out_pix_r;
  logic          out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_l[LS]) begin
      out_v_r <= v_l[LS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_l[LS] && v_l[LS-1]) begin
      for (int ch = 0; ch < 3; ch++) begin
        out_pix_r[ch*PW +: PW] <= (filt_l[LS-1] && chen_r[ch]) ?
                                  lane_res[ch] : pass_l[LS-1][ch*PW +: PW];
      end
      out_last_r <= last_l[LS-1];
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.red_out    = out_pix_r[PW-1:0];
  assign out_ch.green_out  = out_pix_r[2*PW-1:PW];
  assign out_ch.blue_out   = out_pix_r[3*PW-1:2*PW];
  assign out_ch.frame_last = out_last_r;

`ifndef NO_ASSERTIONS
  // a stalled stage A keeps its item and its line store address
  a_stage_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_a && !en_b |=> v_a && $stable(addr_a) && $stable(pix_a))
    else $error("stage A item changed while stalled");

  // frame end is only ever flagged on a column zero emission
  a_last_col0: assert property (@(posedge clk) disable iff (!rst_n)
    v_a && last_a |-> (addr_a == '0) && emit_a)
    else $error("frame end flagged away from column zero");

  // every stored item reaches stage A on the next cycle
  a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !ignore |=> v_a)
    else $error("accepted item missing from stage A");
`endif

endmodule
